FILE: sv/sgd_pkg.sv
package sgd_pkg;

    localparam int COEF_W     = 32;
    localparam int DIGIT_W    = 16;
    localparam int RADIX_W    = 5;
    localparam int LEVELS_W   = 4;
    localparam int LVL_W      = 3;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int RADIX_MAX  = 16;
    localparam int RADIX_RST  = 8;
    localparam int LEVELS_RST = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 1'b1;

    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        logic              end_of_row;
    } t_in_item;

    typedef struct packed {
        logic signed [DIGIT_W-1:0] digit;
        logic [LVL_W-1:0]          level_index;
        logic                      last_digit;
        logic                      row_end;
        logic                      config_error;
    } t_out_item;

    typedef struct packed {
        logic [RADIX_W-1:0]  radix;
        logic [LEVELS_W-1:0] levels;
        logic                err;
    } t_cfg;

    typedef struct packed {
        t_cfg cfg;
        logic eor;
    } t_job;

endpackage

FILE: sv/sgd_cfg.sv
module sgd_cfg
    import sgd_pkg::*;
#(
    parameter int TORUS_BITS = 32,
    parameter int MAX_LEVELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    output t_cfg                  o_cfg,
    output logic [TORUS_BITS-1:0] o_addend
);

    localparam int TB = TORUS_BITS;
    localparam logic [TB-1:0] ONE = TB'(1);
    localparam logic [LEVELS_W-1:0] LEVELS_MAX = LEVELS_W'(MAX_LEVELS);
    localparam logic [LEVELS_W-1:0] LEVELS_INIT =
        (LEVELS_RST < MAX_LEVELS) ? LEVELS_W'(LEVELS_RST) : LEVELS_W'(MAX_LEVELS);

    logic [RADIX_W-1:0]  r_radix;
    logic [LEVELS_W-1:0] r_levels;
    logic [RADIX_W-1:0]  n_radix;
    logic [LEVELS_W-1:0] n_levels;
    logic [8:0]          kept;
    logic [8:0]          shift;
    logic                err;
    logic [TB-1:0]       n_addend;

    always_comb begin
        n_radix  = i_cfg_wdata[RADIX_W-1:0];
        n_levels = i_cfg_wdata[LEVELS_W-1:0];
        if (n_radix == '0) begin
            n_radix = RADIX_W'(1);
        end else if (n_radix > RADIX_W'(RADIX_MAX)) begin
            n_radix = RADIX_W'(RADIX_MAX);
        end
        if (n_levels == '0) begin
            n_levels = LEVELS_W'(1);
        end else if (n_levels > LEVELS_MAX) begin
            n_levels = LEVELS_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_W'(RADIX_RST);
            r_levels <= LEVELS_INIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_RADIX:  r_radix  <= n_radix;
                REG_LEVELS: r_levels <= n_levels;
                default: ;
            endcase
        end
    end

    assign kept  = 9'(r_levels) * 9'(r_radix);
    assign err   = kept > 9'(TB);
    assign shift = 9'(TB) - kept;

    // rounding half-unit plus a half-digit offset at the top of every window
    always_comb begin
        n_addend = '0;
        if (!err) begin
            if (shift != '0) begin
                n_addend = n_addend | (ONE << (shift - 9'd1));
            end
            for (int j = 0; j < MAX_LEVELS; j++) begin
                if (LEVELS_W'(j) < r_levels) begin
                    n_addend = n_addend | (ONE << (TB - 1 - j * int'(r_radix)));
                end
            end
        end
    end

    assign o_cfg.radix  = r_radix;
    assign o_cfg.levels = r_levels;
    assign o_cfg.err    = err;
    assign o_addend     = n_addend;

endmodule

FILE: sv/sgd_front.sv
module sgd_front
    import sgd_pkg::*;
#(
    parameter int TORUS_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  t_in_item              i_item,
    input  t_cfg                  i_cfg,
    input  logic [TORUS_BITS-1:0] i_addend,
    input  logic                  i_take,
    output logic                  o_busy,
    output logic                  o_valid,
    output logic [TORUS_BITS-1:0] o_value,
    output t_job                  o_job
);

    localparam int TB = TORUS_BITS;

    logic                 r_s1_valid;
    logic [TB-1:0]        r_s1_coef;
    logic [TB-1:0]        r_s1_addend;
    t_job                 r_s1_job;
    logic                 r_s2_valid;
    logic [TB-1:0]        r_s2_value;
    t_job                 r_s2_job;
    logic [TB+COEF_W-1:0] coef_wide;
    logic                 s2_free;
    logic                 s1_free;
    logic                 accept;

    assign coef_wide = {{TB{1'b0}}, i_item.coefficient};
    assign s2_free   = !r_s2_valid || i_take;
    assign s1_free   = !r_s1_valid || s2_free;
    assign accept    = i_start && s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= accept;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_coef    <= coef_wide[TB-1:0];
            r_s1_addend  <= i_addend;
            r_s1_job.cfg <= i_cfg;
            r_s1_job.eor <= i_item.end_of_row;
        end
        if (s2_free && r_s1_valid) begin
            r_s2_value <= r_s1_coef + r_s1_addend;
            r_s2_job   <= r_s1_job;
        end
    end

    assign o_busy  = !s1_free;
    assign o_valid = r_s2_valid;
    assign o_value = r_s2_value;
    assign o_job   = r_s2_job;

endmodule

FILE: sv/sgd_serial.sv
module sgd_serial
    import sgd_pkg::*;
#(
    parameter int TORUS_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [TORUS_BITS-1:0] i_value,
    input  t_job                  i_job,
    output logic                  o_take,
    output logic                  o_valid,
    output t_out_item             o_result
);

    localparam int TB = TORUS_BITS;

    logic                  r_valid;
    logic [TB-1:0]         r_value;
    t_job                  r_job;
    logic [LVL_W-1:0]      r_lvl;
    logic                  r_out_valid;
    t_out_item             r_out;
    logic                  last;
    logic                  load;
    logic [6:0]            shamt;
    logic [TB-1:0]         top_bits;
    logic [TB+DIGIT_W-1:0] top_wide;
    logic [DIGIT_W-1:0]    window;
    logic [DIGIT_W-1:0]    half;
    logic [DIGIT_W-1:0]    digit;

    assign last   = r_lvl == LVL_W'(r_job.cfg.levels - LEVELS_W'(1));
    assign load   = !r_valid || last;
    assign o_take = i_valid && load;

    // window of the current level sits at the top; drop the half-digit offset
    assign shamt    = 7'(TB - int'(r_job.cfg.radix));
    assign top_bits = r_value >> shamt;
    assign top_wide = {{DIGIT_W{1'b0}}, top_bits};
    assign window   = top_wide[DIGIT_W-1:0];
    assign half     = DIGIT_W'(1) << (r_job.cfg.radix - RADIX_W'(1));
    assign digit    = r_job.cfg.err ? '0 : window - half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_valid;
            if (load) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_value <= i_value;
            r_job   <= i_job;
            r_lvl   <= '0;
        end else begin
            r_value <= r_value << r_job.cfg.radix;
            r_lvl   <= r_lvl + LVL_W'(1);
        end
        r_out.digit        <= digit;
        r_out.level_index  <= r_lvl;
        r_out.last_digit   <= last;
        r_out.row_end      <= last && r_job.eor;
        r_out.config_error <= r_job.cfg.err;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: sv/signed_gadget_decomposition.sv
// channel   direction  handshake          payload
// input     in         start / busy       i_item   (t_in_item)
// result    out        o_valid strobe     o_result (t_out_item)
// config    in         i_cfg_we           i_cfg_index, i_cfg_wdata
//
// One digit leaves per cycle, so a coefficient occupies the digit serializer until its
// last digit; a waiting coefficient is loaded while that digit is formed. After the
// accepting edge the first digit passes front stage two, the serializer and the output
// register. busy is high when both front stages are full and the serializer holds a
// coefficient not yet on its last digit. Synchronous active-low reset empties all stages
// and restores radix_bits 8, levels 3. Results cannot be stalled.
module signed_gadget_decomposition
    import sgd_pkg::*;
#(
    parameter int TORUS_BITS = 32,
    parameter int MAX_LEVELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output logic                 o_valid,
    output t_out_item            o_result
);

    t_cfg                  cfg;
    logic [TORUS_BITS-1:0] addend;
    logic                  take;
    logic                  s2_valid;
    logic [TORUS_BITS-1:0] s2_value;
    t_job                  s2_job;

    sgd_cfg #(
        .TORUS_BITS(TORUS_BITS),
        .MAX_LEVELS(MAX_LEVELS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg),
        .o_addend    (addend)
    );

    sgd_front #(
        .TORUS_BITS(TORUS_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .i_cfg    (cfg),
        .i_addend (addend),
        .i_take   (take),
        .o_busy   (busy),
        .o_valid  (s2_valid),
        .o_value  (s2_value),
        .o_job    (s2_job)
    );

    sgd_serial #(
        .TORUS_BITS(TORUS_BITS)
    ) u_serial (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s2_valid),
        .i_value  (s2_value),
        .i_job    (s2_job),
        .o_take   (take),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    a_digits_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last_digit |=> o_valid)
        else $error("digit transaction gap inside a coefficient");

    a_level_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.last_digit |=>
            o_result.level_index == $past(o_result.level_index) + LVL_W'(1))
        else $error("level index did not advance");

    a_row_end_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.row_end |-> o_result.last_digit)
        else $error("row end off the last digit");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.config_error |-> o_result.digit == '0)
        else $error("nonzero digit with config error");

endmodule

FILE: sim/testbench.sv
import sgd_pkg::*;

class digit_scoreboard;
    localparam int TORUS_BITS  = COEF_W;
    localparam int LEVELS_CAP  = 8;

    logic [RADIX_W-1:0]  radix_reg;
    logic [LEVELS_W-1:0] levels_reg;
    t_out_item           pending_digits[$];
    int                  errors;
    int                  coefficients;
    int                  digits_checked;
    int                  error_path_coefficients;

    function new();
        radix_reg = RADIX_RST;
        levels_reg = LEVELS_RST;
        errors = 0;
        coefficients = 0;
        digits_checked = 0;
        error_path_coefficients = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
        if (index == REG_RADIX) begin
            radix_reg = value[RADIX_W-1:0];
        end else begin
            levels_reg = value[LEVELS_W-1:0];
        end
    endfunction

    task report(string what);
        if (errors < 40) begin
            $display("MISMATCH at %0t: %s", $realtime, what);
        end
        errors++;
    endtask

    // expand one accepted coefficient into its per-level digits
    function void add_coefficient(t_in_item item);
        int            radix;
        int            depth;
        int            kept;
        int            sh;
        bit            oversized;
        logic [63:0]   u;
        logic [63:0]   rnd;
        longint        base;
        longint        half;
        longint        w;
        longint        d;
        longint        carry;
        logic [15:0]   dig[LEVELS_CAP];
        t_out_item     res;
        radix = (radix_reg == 0) ? 1 : (radix_reg > RADIX_MAX) ? RADIX_MAX : int'(radix_reg);
        depth = (levels_reg == 0) ? 1 : (levels_reg > LEVELS_CAP) ? LEVELS_CAP
                                                                  : int'(levels_reg);
        kept = depth * radix;
        oversized = kept > TORUS_BITS;
        foreach (dig[k]) dig[k] = '0;
        if (!oversized) begin
            rnd = (kept < TORUS_BITS) ? (64'd1 << (TORUS_BITS - kept - 1)) : 64'd0;
            u = (64'(item.coefficient) + rnd) & 64'hFFFF_FFFF;
            base = longint'(1) << radix;
            half = base >> 1;
            carry = 0;
            for (int lvl = depth - 1; lvl >= 0; lvl--) begin
                sh = TORUS_BITS - (lvl + 1) * radix;
                w = longint'(u >> sh) & (base - 1);
                d = w + carry;
                if (d >= half) begin
                    carry = 1;
                    d = d - base;
                end else begin
                    carry = 0;
                end
                dig[lvl] = d[15:0];
            end
        end
        for (int k = 0; k < depth; k++) begin
            res.digit = dig[k];
            res.level_index = LVL_W'(k);
            res.last_digit = (k == depth - 1);
            res.row_end = (k == depth - 1) && item.end_of_row;
            res.config_error = oversized;
            pending_digits.push_back(res);
        end
        coefficients++;
        if (oversized) error_path_coefficients++;
    endfunction

    task check_digit(t_out_item got);
        t_out_item want;
        if (pending_digits.size() == 0) begin
            report($sformatf("unexpected digit %0d level %0d", got.digit, got.level_index));
        end else begin
            want = pending_digits.pop_front();
            digits_checked++;
            if (got.digit !== want.digit)
                report($sformatf("digit %0d, expected %0d (level %0d)",
                                 got.digit, want.digit, want.level_index));
            if (got.level_index !== want.level_index)
                report($sformatf("level_index %0d, expected %0d",
                                 got.level_index, want.level_index));
            if (got.last_digit !== want.last_digit)
                report($sformatf("last_digit %0b, expected %0b (level %0d)",
                                 got.last_digit, want.last_digit, want.level_index));
            if (got.row_end !== want.row_end)
                report($sformatf("row_end %0b, expected %0b (level %0d)",
                                 got.row_end, want.row_end, want.level_index));
            if (got.config_error !== want.config_error)
                report($sformatf("config_error %0b, expected %0b",
                                 got.config_error, want.config_error));
        end
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_FIXED        = 12;
    localparam int NUM_PHASES       = 20;
    localparam int RANDOM_PER_PHASE = 22;
    localparam int CYCLE_LIMIT      = 100000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 o_valid;
    t_out_item            o_result;

    digit_scoreboard sb;
    int              cycle_count = 0;

    const int fixed_radix[NUM_FIXED]  = '{8, 0, 31, 16, 4, 1, 5, 17, 8, 11, 3, 12};
    const int fixed_levels[NUM_FIXED] = '{3, 0, 15, 2, 8, 8, 6, 1, 4, 3, 10, 2};
    const logic [31:0] edge_values[4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                           32'h8000_0000, 32'h7FFF_FFFF};

    signed_gadget_decomposition dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            sb.check_digit(o_result);
        end
    end

    // hold start until the transaction is taken; returns at a falling edge
    task automatic drive_coefficient(input logic [31:0] coefficient, input logic eor);
        t_in_item item;
        bit       taken;
        item.coefficient = coefficient;
        item.end_of_row = eor;
        start <= 1'b1;
        i_item <= item;
        taken = 0;
        while (!taken) begin
            @(posedge i_clk);
            taken = (busy === 1'b0);
            if (taken) sb.add_coefficient(item);
            @(negedge i_clk);
        end
    endtask

    task automatic idle_sender(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending_digits.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] radix, input logic [CFG_W-1:0] depth);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_RADIX;
        i_cfg_wdata <= radix;
        sb.set_register(REG_RADIX, radix);
        @(negedge i_clk);
        i_cfg_index <= REG_LEVELS;
        i_cfg_wdata <= depth;
        sb.set_register(REG_LEVELS, depth);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int          ph;
        int          k;
        int          radix;
        int          depth;
        bit          quiet;
        bit          gappy;
        logic [31:0] coef;
        start = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_rst_n = 1'b0;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                if (ph < NUM_FIXED) begin
                    radix = fixed_radix[ph];
                    depth = fixed_levels[ph];
                end else begin
                    radix = $urandom_range(0, 31);
                    depth = $urandom_range(0, 31);
                end
                write_settings(CFG_W'(radix), CFG_W'(depth));
            end
            quiet = (ph >= NUM_PHASES - 3);
            gappy = !quiet && ($urandom_range(0, 3) != 0);

            if (ph == 0) begin
                drive_coefficient(32'h0000_007F, 1'b0);
                drive_coefficient(32'h0000_0080, 1'b1);
            end
            if (ph < 5) begin
                for (k = 0; k < 4; k++) begin
                    drive_coefficient(edge_values[k], k[0]);
                end
            end

            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                case ($urandom_range(0, 3))
                    0, 1: coef = $urandom;
                    2: coef = 32'h8080_8080 ^ $urandom_range(0, 255);
                    default: coef = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 1023)
                                                         : $urandom_range(0, 1023);
                endcase
                if (gappy && $urandom_range(0, 3) == 0) begin
                    idle_sender($urandom_range(1, 3));
                end
                drive_coefficient(coef, $urandom_range(0, 1));
            end

            start <= 1'b0;
            wait_drained();
        end

        repeat (12) @(negedge i_clk);
        if (sb.pending_digits.size() != 0) begin
            sb.report($sformatf("%0d digits never arrived", sb.pending_digits.size()));
        end
        $display("Checked %0d digits from %0d coefficients over %0d radix/level settings",
                 sb.digits_checked, sb.coefficients, NUM_PHASES);
        $display("%0d coefficients went through the oversized-setting error path",
                 sb.error_path_coefficients);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
